### src/rtbw_pkg.sv
// Package for the rotate/translate bilinear warp: constants, register codes,
// pipeline structs and clamp functions. Depends on nothing.
package rtbw_pkg;

	localparam int FRAC_BITS = 8;
	localparam int COORD_W   = 20;
	localparam int BANK_AW   = 16;
	localparam int BANK_DEPTH = 65536;
	localparam int NUM_BANKS = 4;

	localparam logic [2:0] REG_ROT_COS   = 3'd0;
	localparam logic [2:0] REG_ROT_SIN   = 3'd1;
	localparam logic [2:0] REG_SHIFT_X   = 3'd2;
	localparam logic [2:0] REG_SHIFT_Y   = 3'd3;
	localparam logic [2:0] REG_WIDTH     = 3'd4;
	localparam logic [2:0] REG_HEIGHT    = 3'd5;
	localparam logic [2:0] REG_CHANNELS  = 3'd6;

	localparam logic OP_LOAD = 1'b0;

	typedef struct packed {
		logic        valid;
		logic        load;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [1:0]  pl;
		logic [15:0] pix;
	} meta_t;

	typedef struct packed {
		meta_t      meta;
		logic       hit;
		logic [7:0] ix;
		logic [7:0] iy;
		logic [7:0] fx;
		logic [7:0] fy;
	} samp_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [1:0]  pl;
		logic [15:0] value;
		logic        hit;
	} res_t;

	function automatic logic [8:0] clamp_dim(input logic [8:0] v);
		logic [8:0] r;
		r = v;
		if (v < 9'd2) r = 9'd2;
		else if (v > 9'd256) r = 9'd256;
		return r;
	endfunction

	function automatic logic [2:0] clamp_planes(input logic [2:0] v);
		logic [2:0] r;
		r = v;
		if (v == 3'd0) r = 3'd1;
		else if (v > 3'd4) r = 3'd4;
		return r;
	endfunction

endpackage

### src/rtbw_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module rtbw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) mem[addr] <= wdata;
			rdata <= mem[addr];
		end
	end
endmodule

### src/rtbw_map.sv
// Coordinate mapping pipeline: shift, inverse rotation, rounding, inside test.
// Depends on rtbw_pkg.
module rtbw_map import rtbw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  meta_t              item,
	input  logic signed [15:0] rot_cos,
	input  logic signed [15:0] rot_sin,
	input  logic [16:0]        shift_x,
	input  logic [16:0]        shift_y,
	input  logic [8:0]         width,
	input  logic [8:0]         height,
	output samp_t              samp
);
	meta_t meta_s1, meta_s2, meta_s3;
	logic signed [18:0] xt_s1, yt_s1;
	logic signed [34:0] pcx_s2, psy_s2, pcy_s2, psx_s2;
	logic signed [COORD_W-1:0] sx_s3, sy_s3;
	samp_t samp_s4;

	logic signed [18:0] xt, yt;
	logic signed [35:0] sum_x, sum_y;
	logic [16:0] lim_x, lim_y;
	logic in_x, in_y;

	assign xt = $signed({3'b0, item.x, 8'b0}) - $signed({{2{shift_x[16]}}, shift_x});
	assign yt = $signed({3'b0, item.y, 8'b0}) - $signed({{2{shift_y[16]}}, shift_y});

	assign sum_x = 36'(pcx_s2) + 36'(psy_s2) + 36'sd8192;
	assign sum_y = 36'(pcy_s2) - 36'(psx_s2) + 36'sd8192;

	assign lim_x = {width - 9'd1, 8'b0};
	assign lim_y = {height - 9'd1, 8'b0};
	assign in_x = !sx_s3[COORD_W-1] && (sx_s3[COORD_W-2:0] <= {2'b0, lim_x});
	assign in_y = !sy_s3[COORD_W-1] && (sy_s3[COORD_W-2:0] <= {2'b0, lim_y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
			samp_s4 <= '0;
		end else if (en) begin
			meta_s1 <= item;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			samp_s4.meta   <= meta_s3;
			samp_s4.hit    <= in_x && in_y;
			samp_s4.ix     <= sx_s3[15:8];
			samp_s4.iy     <= sy_s3[15:8];
			samp_s4.fx     <= sx_s3[7:0];
			samp_s4.fy     <= sy_s3[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xt_s1  <= xt;
			yt_s1  <= yt;
			pcx_s2 <= rot_cos * xt_s1;
			psy_s2 <= rot_sin * yt_s1;
			pcy_s2 <= rot_cos * yt_s1;
			psx_s2 <= rot_sin * xt_s1;
			sx_s3  <= sum_x[33:14];
			sy_s3  <= sum_y[33:14];
		end
	end

	assign samp = samp_s4;
endmodule

### src/rtbw_blend.sv
// Bilinear blend of the four banked neighbors, rounding and saturation.
// Depends on rtbw_pkg.
module rtbw_blend import rtbw_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  samp_t                       samp,
	input  logic [NUM_BANKS-1:0][15:0]  bank_rd,
	output res_t                        res
);
	meta_t meta_s5, meta_s6, meta_s7;
	logic ins_s5, ins_s6, ins_s7;
	logic [7:0] fx_s5, fy_s5, fy_s6;
	logic ix0_s5, iy0_s5;
	logic [24:0] top_s6, bot_s6;
	logic [33:0] acc_s7;

	meta_t meta_in;
	logic [15:0] tl, tr, bl, br;
	logic [8:0] wx0, wy0;
	logic [33:0] rnd;

	// A neighbor with zero weight takes a tap that is known to be in the frame,
	// which covers the clamped last row and column.
	assign tl = bank_rd[{iy0_s5, ix0_s5}];
	assign tr = (fx_s5 == 8'd0) ? tl : bank_rd[{iy0_s5, ~ix0_s5}];
	assign bl = (fy_s5 == 8'd0) ? tl : bank_rd[{~iy0_s5, ix0_s5}];
	assign br = (fy_s5 == 8'd0) ? tr : ((fx_s5 == 8'd0) ? bl : bank_rd[{~iy0_s5, ~ix0_s5}]);
	assign wx0 = 9'd256 - {1'b0, fx_s5};
	assign wy0 = 9'd256 - {1'b0, fy_s6};
	assign rnd = acc_s7 + 34'd32768;

	always_comb begin
		meta_in = samp.meta;
		meta_in.valid = samp.meta.valid && (samp.meta.load != OP_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s5 <= '0;
			meta_s6 <= '0;
			meta_s7 <= '0;
		end else if (en) begin
			meta_s5 <= meta_in;
			meta_s6 <= meta_s5;
			meta_s7 <= meta_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ins_s5 <= samp.hit;
			fx_s5  <= samp.fx;
			fy_s5  <= samp.fy;
			ix0_s5 <= samp.ix[0];
			iy0_s5 <= samp.iy[0];
			ins_s6 <= ins_s5;
			fy_s6  <= fy_s5;
			top_s6 <= 25'(tl) * 25'(wx0) + 25'(tr) * 25'(fx_s5);
			bot_s6 <= 25'(bl) * 25'(wx0) + 25'(br) * 25'(fx_s5);
			ins_s7 <= ins_s6;
			acc_s7 <= 34'(top_s6) * 34'(wy0) + 34'(bot_s6) * 34'(fy_s6);
		end
	end

	always_comb begin
		res.valid  = meta_s7.valid;
		res.x      = meta_s7.x;
		res.y      = meta_s7.y;
		res.pl     = meta_s7.pl;
		res.hit    = ins_s7;
		if (!ins_s7) res.value = 16'd0;
		else if (rnd[32]) res.value = 16'hFFFF;
		else res.value = rnd[31:16];
	end
endmodule

### src/rotate_translate_bilinear_warp.sv
// Rotate/translate warp with bilinear sampling; top level with config, banks, output.
// Throughput is one beat per cycle while no output beat is held back by m_tready.
// The frame store is four row/column parity banks, so a single read yields all
// four neighbors. The whole pipeline stalls while an output beat waits.
// Reset clears configuration to defaults and all valid flags; frame data is kept.
// Depends on rtbw_pkg, rtbw_ram, rtbw_map, rtbw_blend.
module rotate_translate_bilinear_warp import rtbw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // pos_x, pos_y, plane, pixel_in
	input  logic [0:0]  s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // out_col, out_row, out_plane, pixel_out
	output logic [0:0]  m_tuser,  // inside_res
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_wdata
);
	logic signed [15:0] cos_q, sin_q;
	logic [16:0] shx_q, shy_q;
	logic [8:0] w_q, h_q;
	logic [2:0] nch_q;

	logic en;
	meta_t item;
	samp_t samp;
	res_t res, out_q;
	logic [NUM_BANKS-1:0][15:0] bank_rd;
	logic [NUM_BANKS-1:0] bank_we;
	logic [7:0] ix_p1, iy_p1;
	logic req_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= 16'sd16384;
			sin_q <= 16'sd0;
			shx_q <= 17'd0;
			shy_q <= 17'd0;
			w_q   <= 9'd256;
			h_q   <= 9'd256;
			nch_q <= 3'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROT_COS:  cos_q <= cfg_wdata[15:0];
				REG_ROT_SIN:  sin_q <= cfg_wdata[15:0];
				REG_SHIFT_X:  shx_q <= cfg_wdata;
				REG_SHIFT_Y:  shy_q <= cfg_wdata;
				REG_WIDTH:    w_q   <= clamp_dim(cfg_wdata[8:0]);
				REG_HEIGHT:   h_q   <= clamp_dim(cfg_wdata[8:0]);
				REG_CHANNELS: nch_q <= clamp_planes(cfg_wdata[2:0]);
				default: ;
			endcase
		end
	end

	assign en = !out_q.valid || m_tready;
	assign s_tready = en;

	assign req_ok = ({1'b0, s_tdata[7:0]} < w_q) && ({1'b0, s_tdata[15:8]} < h_q)
		&& ({1'b0, s_tdata[17:16]} < nch_q);

	always_comb begin
		item.load  = s_tuser[0];
		item.x     = s_tdata[7:0];
		item.y     = s_tdata[15:8];
		item.pl    = s_tdata[17:16];
		item.pix   = s_tdata[33:18];
		item.valid = s_tvalid && ((s_tuser[0] == OP_LOAD) || req_ok);
	end

	rtbw_map u_map (
		.clk(clk), .arst_n(arst_n), .en(en), .item(item),
		.rot_cos(cos_q), .rot_sin(sin_q), .shift_x(shx_q), .shift_y(shy_q),
		.width(w_q), .height(h_q), .samp(samp)
	);

	assign ix_p1 = samp.ix + 8'd1;
	assign iy_p1 = samp.iy + 8'd1;

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		localparam logic RB = 1'(b >> 1);
		localparam logic CB = 1'(b & 1);
		logic [BANK_AW-1:0] addr;
		logic [6:0] rh, ch;
		always_comb begin
			rh = RB ? samp.iy[7:1] : iy_p1[7:1];
			ch = CB ? samp.ix[7:1] : ix_p1[7:1];
			if (samp.meta.load == OP_LOAD)
				addr = {samp.meta.pl, samp.meta.y[7:1], samp.meta.x[7:1]};
			else
				addr = {samp.meta.pl, rh, ch};
		end
		assign bank_we[b] = en && samp.meta.valid && (samp.meta.load == OP_LOAD)
			&& (samp.meta.y[0] == RB) && (samp.meta.x[0] == CB);
		rtbw_ram #(.WIDTH(16), .DEPTH(BANK_DEPTH)) u_ram (
			.clk(clk), .en(en), .we(bank_we[b]), .addr(addr),
			.wdata(samp.meta.pix), .rdata(bank_rd[b])
		);
	end

	rtbw_blend u_blend (
		.clk(clk), .arst_n(arst_n), .en(en), .samp(samp), .bank_rd(bank_rd), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_q <= '0;
		else if (en) out_q <= res;
	end

	assign m_tvalid = out_q.valid;
	assign m_tdata  = {6'd0, out_q.value, out_q.pl, out_q.y, out_q.x};
	assign m_tuser  = out_q.hit;

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[33:18] == 16'd0)
		else $error("outside point with nonzero value");
	a_one_bank: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(bank_we))
		else $error("more than one bank written");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(samp))
		else $error("pipeline moved while stalled");
endmodule
